// ===== rtl/mdsha_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 / SHA-1 engine package
// Shared types and constants for the hash engine and its channel interfaces.
// ----------------------------------------------------------------------------
package mdsha_pkg;

    localparam logic [1:0] KIND_APPEND   = 2'd0;
    localparam logic [1:0] KIND_QUERY    = 2'd1;
    localparam logic [1:0] KIND_RESTART  = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data_bytes;
        logic [2:0]  byte_count;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_bytes;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf,
            32'h4787c62a, 32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af,
            32'hffff5bb1, 32'h895cd7be, 32'h6b901122, 32'hfd987193, 32'ha679438e,
            32'h49b40821, 32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8, 32'h21e1cde6,
            32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
            32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122,
            32'hfde5380c, 32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05, 32'hd9d4d039,
            32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665, 32'hf4292244, 32'h432aff97,
            32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d,
            32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        return k[i];
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== rtl/mdsha_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface mdsha_in_if import mdsha_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mdsha_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one digest word.
// ----------------------------------------------------------------------------
interface mdsha_out_if import mdsha_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/mdsha_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the algorithm register.
// ----------------------------------------------------------------------------
interface mdsha_cfg_if ();
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/md5_sha1_hash_engine_core.sv =====
// ----------------------------------------------------------------------------
// MD5 / SHA-1 hash engine core
// Incremental MD5 or SHA-1 with a non-destructive digest query.
// ----------------------------------------------------------------------------
//  channel   direction  word
//  i_cmd     in         kind, data_bytes, byte_count
//  o_dig     out        digest_bytes, word_index, last_word
//  i_cfg     in         algorithm select (0 MD5, 1 SHA-1)
//
// One shared round unit does one round per cycle: a block is loaded into the
// working words, runs its MD5 or SHA-1 rounds and is then added into the
// chaining words. An append stores its bytes into the block buffer one at a
// time, with a compression whenever a block fills. A query pads a shadow copy
// of the block, runs one or two compressions, then loads and delivers the
// digest words in order. Restart completes on acceptance. Reset is synchronous
// and active low. The block is not ready for a new word until the current one
// is done; a stalled result simply holds.
// ----------------------------------------------------------------------------
module md5_sha1_hash_engine_core
    import mdsha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    mdsha_in_if.sink    i_cmd,
    mdsha_cfg_if.sink   i_cfg,
    mdsha_out_if.source o_dig
);

    typedef enum logic [2:0] {
        S_IDLE, S_APPEND, S_PAD, S_ROUND, S_FOLD, S_EMIT
    } t_state;

    t_state       r_state;
    logic         r_alg;        // register value
    logic         r_act;        // active algorithm
    logic [31:0]  r_h [5];
    logic [60:0]  r_cnt;
    logic [31:0]  r_buf [16];
    // Working block: either the live buffer copy or the shadow for a query.
    logic [31:0]  r_w [16];
    logic [31:0]  r_sh [5];     // chaining words under compression
    logic [31:0]  r_r [5];      // round working words
    logic [6:0]   r_rnd;
    logic         r_query;      // compression belongs to a query
    logic         r_second;     // a length-only block still follows
    logic [31:0]  r_data;
    logic [2:0]   r_left;
    logic [2:0]   r_oidx;
    logic         r_ovalid;
    logic [31:0]  r_odata;

    // Shared round unit.
    logic [31:0] f, t, wi, md_sum;
    logic [3:0]  g;
    logic [6:0]  rr;
    logic [5:0]  r6;
    logic [31:0] sha_w;
    logic [2:0]  clamp;

    // The counter runs one ahead of the round, since its first cycle loads.
    assign rr = r_rnd - 7'd1;
    assign r6 = rr[5:0];

    always_comb begin
        f = '0;
        g = r6[3:0];
        if (!r_act) begin
            unique case (r6[5:4])
                2'd0: begin f = (r_r[1] & r_r[2]) | (~r_r[1] & r_r[3]); g = r6[3:0]; end
                2'd1: begin
                    f = (r_r[1] & r_r[3]) | (r_r[2] & ~r_r[3]);
                    g = 4'({r6, 2'b00} + r6 + 8'd1);
                end
                2'd2: begin f = r_r[1] ^ r_r[2] ^ r_r[3]; g = 4'({r6, 1'b0} + r6 + 7'd5); end
                default: begin f = r_r[2] ^ (r_r[1] | ~r_r[3]); g = 4'({r6, 3'b0} - r6); end
            endcase
        end else if (rr < 7'd20) begin
            f = r_r[3] ^ (r_r[1] & (r_r[2] ^ r_r[3]));
        end else if (rr < 7'd40 || rr >= 7'd60) begin
            f = r_r[1] ^ r_r[2] ^ r_r[3];
        end else begin
            f = (r_r[1] & r_r[2]) | (r_r[3] & (r_r[1] | r_r[2]));
        end
        md_sum = r_r[0] + f + md5_k(r6) + r_w[g];
        // SHA-1 message schedule runs in place over the 16-word window,
        // stored big-endian-swapped before the first round.
        wi = r_w[rr[3:0]];
        if (rr >= 7'd16) begin
            sha_w = r_w[4'(rr - 7'd3)] ^ r_w[4'(rr - 7'd8)]
                  ^ r_w[4'(rr - 7'd14)] ^ r_w[rr[3:0]];
            wi    = {sha_w[30:0], sha_w[31]};
        end else begin
            sha_w = '0;
        end
        t = {r_r[0][26:0], r_r[0][31:27]} + f + r_r[4] + wi +
            ((rr < 7'd20) ? 32'h5A827999 : (rr < 7'd40) ? 32'h6ED9EBA1 :
             (rr < 7'd60) ? 32'h8F1BBCDC : 32'hCA62C1D6);
    end

    assign clamp = (i_cmd.payload.byte_count > 3'd4) ? 3'd4 : i_cmd.payload.byte_count;

    assign i_cmd.ready = (r_state == S_IDLE) && !r_ovalid;
    assign i_cfg.ready = 1'b1;
    assign o_dig.valid = r_ovalid;
    assign o_dig.payload.digest_bytes = r_odata;
    assign o_dig.payload.word_index   = r_oidx;
    assign o_dig.payload.last_word    = r_act ? (r_oidx == 3'd4) : (r_oidx == 3'd3);

    logic [5:0]  pos;
    logic [63:0] bits;
    assign pos  = r_cnt[5:0];
    assign bits = {r_cnt, 3'b000};

    // Block images: the full block as the last byte arrives, the padded
    // shadow block and the length-only block.
    logic [31:0] blk_last [16];
    logic [31:0] pad_w [16];
    logic [31:0] len_w [16];

    always_comb begin
        blk_last = r_buf;
        blk_last[15][31:24] = r_data[7:0];
        len_w = '{default: 32'd0};
        len_w[14] = r_act ? bswap(bits[63:32]) : bits[31:0];
        len_w[15] = r_act ? bswap(bits[31:0]) : bits[63:32];
        pad_w = r_w;
        for (int k = 0; k < 64; k++) begin
            if (6'(k) == pos) pad_w[k/4][8*(k%4) +: 8] = 8'h80;
            else if (6'(k) > pos) pad_w[k/4][8*(k%4) +: 8] = 8'h00;
        end
        if (pos < 6'd56) begin
            pad_w[14] = len_w[14];
            pad_w[15] = len_w[15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alg    <= 1'b0;
            r_act    <= 1'b0;
            r_h      <= '{IV0, IV1, IV2, IV3, 32'd0};
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_query  <= 1'b0;
            r_second <= 1'b0;
            r_rnd    <= '0;
            r_left   <= '0;
            r_oidx   <= '0;
        end else begin
            if (i_cfg.valid) r_alg <= i_cfg.data;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid && i_cmd.ready) begin
                        r_data <= i_cmd.payload.data_bytes;
                        r_left <= clamp;
                        case (i_cmd.payload.kind)
                            KIND_APPEND: if (clamp != 3'd0) r_state <= S_APPEND;
                            KIND_QUERY: begin
                                r_w   <= r_buf;
                                r_sh  <= r_h;
                                r_query <= 1'b1;
                                r_state <= S_PAD;
                            end
                            KIND_RESTART: begin
                                r_act <= r_alg;
                                r_h   <= '{IV0, IV1, IV2, IV3, r_alg ? IV4 : 32'd0};
                                r_cnt <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_APPEND: begin
                    // One byte a cycle into the block buffer.
                    r_buf[pos[5:2]][8*pos[1:0] +: 8] <= r_data[7:0];
                    r_data <= r_data >> 8;
                    r_left <= r_left - 3'd1;
                    r_cnt  <= r_cnt + 61'd1;
                    if (pos == 6'd63) begin
                        r_w <= blk_last;
                        r_sh <= r_h;
                        r_query <= 1'b0;
                        r_rnd <= '0;
                        r_state <= S_ROUND;
                    end else if (r_left == 3'd1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    // Pad the shadow block: 0x80 then zeros, length if room.
                    r_w <= pad_w;
                    r_second <= (pos >= 6'd56);
                    r_rnd <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    if (r_rnd == 7'd0) begin
                        // Load working words; SHA-1 also swaps the block once.
                        r_r <= r_sh;
                        if (r_act) for (int k = 0; k < 16; k++) r_w[k] <= bswap(r_w[k]);
                        r_rnd <= 7'd1;
                        r_state <= S_ROUND;
                    end else begin
                        if (!r_act) begin
                            r_r[0] <= r_r[3];
                            r_r[3] <= r_r[2];
                            r_r[2] <= r_r[1];
                            r_r[1] <= r_r[1] + ((md_sum << md5_s(r6)) |
                                               (md_sum >> (6'd32 - 6'(md5_s(r6)))));
                        end else begin
                            if (rr >= 7'd16) r_w[rr[3:0]] <= wi;
                            r_r[4] <= r_r[3];
                            r_r[3] <= r_r[2];
                            r_r[2] <= {r_r[1][1:0], r_r[1][31:2]};
                            r_r[1] <= r_r[0];
                            r_r[0] <= t;
                        end
                        r_rnd <= r_rnd + 7'd1;
                    end
                end
                default: ;
            endcase
            if (r_state == S_FOLD) begin
                for (int k = 0; k < 5; k++) r_sh[k] <= r_sh[k] + r_r[k];
                if (!r_query) begin
                    for (int k = 0; k < 5; k++) r_h[k] <= r_h[k] + r_r[k];
                    r_state <= (r_left == 3'd0) ? S_IDLE : S_APPEND;
                end else if (r_second) begin
                    r_second <= 1'b0;
                    r_w <= len_w;
                    r_rnd <= '0;
                    r_state <= S_ROUND;
                end else begin
                    r_oidx <= '0;
                    r_state <= S_EMIT;
                end
            end
            if (r_state == S_EMIT && (!r_ovalid || o_dig.ready)) begin
                if (r_ovalid && o_dig.payload.last_word) begin
                    r_ovalid <= 1'b0;
                    r_state  <= S_IDLE;
                end else begin
                    r_ovalid <= 1'b1;
                    r_odata  <= r_act ? bswap(r_sh[r_ovalid ? r_oidx + 3'd1 : 3'd0])
                                      : r_sh[r_ovalid ? r_oidx + 3'd1 : 3'd0];
                    r_oidx   <= r_ovalid ? r_oidx + 3'd1 : 3'd0;
                end
            end
            if (r_state == S_ROUND && r_rnd != 7'd0) begin
                if (!r_act) begin
                    if (r_rnd == 7'd64) r_state <= S_FOLD;
                end else begin
                    if (r_rnd == 7'd80) r_state <= S_FOLD;
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_md5_sha1_hash_engine_core.sv =====
// ----------------------------------------------------------------------------
// MD5 / SHA-1 hash engine core testbench
// Drives append, query, restart and reserved words in bursts with a stalling
// result side, predicts every digest word and compares each one as it comes.
// ----------------------------------------------------------------------------
module tb_md5_sha1_hash_engine_core;
    import mdsha_pkg::*;

    // Model of the engine: running hash, pending block and expected digest words.
    class digest_scoreboard;
        bit [31:0] chain [5];
        bit [31:0] blk [16];
        bit [60:0] nbytes;
        bit        alg_reg;
        bit        alg_act;
        t_out_word pending [$];
        int        errors;

        function void init();
            alg_reg = 1'b0;
            alg_act = 1'b0;
            foreach (blk[i]) blk[i] = '0;
            load_iv();
            errors = 0;
        endfunction

        function void load_iv();
            chain[0] = IV0;
            chain[1] = IV1;
            chain[2] = IV2;
            chain[3] = IV3;
            chain[4] = alg_act ? IV4 : 32'h0;
            nbytes = '0;
        endfunction

        function automatic bit [31:0] rotl(bit [31:0] x, int s);
            s = s % 32;
            return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
        endfunction

        function automatic bit [31:0] swap(bit [31:0] x);
            return {x[7:0], x[15:8], x[23:16], x[31:24]};
        endfunction

        function automatic void compress(ref bit [31:0] h [5], input bit [31:0] b [16]);
            bit [31:0] r [5];
            bit [31:0] w [80];
            bit [31:0] f, t, k;
            int g, rnd;
            int sh [4][4];
            sh = '{'{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}};
            for (int i = 0; i < 5; i++) r[i] = h[i];
            if (!alg_act) begin
                for (int i = 0; i < 64; i++) begin
                    rnd = i / 16;
                    case (rnd)
                        0: begin f = (r[1] & r[2]) | (~r[1] & r[3]); g = i; end
                        1: begin f = (r[1] & r[3]) | (r[2] & ~r[3]); g = 5 * i + 1; end
                        2: begin f = r[1] ^ r[2] ^ r[3]; g = 3 * i + 5; end
                        default: begin f = r[2] ^ (r[1] | ~r[3]); g = 7 * i; end
                    endcase
                    t = r[3];
                    r[3] = r[2];
                    r[2] = r[1];
                    r[1] = r[1] + rotl(r[0] + f + md5_k(i[5:0]) + b[g % 16], sh[rnd][i % 4]);
                    r[0] = t;
                end
                for (int i = 0; i < 4; i++) h[i] += r[i];
            end else begin
                for (int i = 0; i < 16; i++) w[i] = swap(b[i]);
                for (int i = 16; i < 80; i++)
                    w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
                for (int i = 0; i < 80; i++) begin
                    if (i < 20) begin f = r[3] ^ (r[1] & (r[2] ^ r[3])); k = 32'h5A827999; end
                    else if (i < 40) begin f = r[1] ^ r[2] ^ r[3]; k = 32'h6ED9EBA1; end
                    else if (i < 60) begin
                        f = (r[1] & r[2]) | (r[3] & (r[1] | r[2]));
                        k = 32'h8F1BBCDC;
                    end else begin f = r[1] ^ r[2] ^ r[3]; k = 32'hCA62C1D6; end
                    t = rotl(r[0], 5) + f + r[4] + k + w[i];
                    r[4] = r[3];
                    r[3] = r[2];
                    r[2] = rotl(r[1], 30);
                    r[1] = r[0];
                    r[0] = t;
                end
                for (int i = 0; i < 5; i++) h[i] += r[i];
            end
        endfunction

        function automatic void put(ref bit [31:0] b [16], input int p, bit [7:0] v);
            b[(p / 4) % 16][8 * (p % 4) +: 8] = v;
        endfunction

        // Called for every accepted command word.
        function void note_command(t_in_word c);
            bit [31:0] sc [5];
            bit [31:0] sb [16];
            bit [63:0] bits;
            int cnt, pos, used, n;
            t_out_word o;
            case (c.kind)
                KIND_APPEND: begin
                    cnt = (c.byte_count > 4) ? 4 : c.byte_count;
                    for (int i = 0; i < cnt; i++) begin
                        pos = nbytes[5:0];
                        put(blk, pos, c.data_bytes[8 * i +: 8]);
                        nbytes = nbytes + 1;
                        if (pos == 63) compress(chain, blk);
                    end
                end
                KIND_RESTART: begin
                    alg_act = alg_reg;
                    load_iv();
                end
                KIND_QUERY: begin
                    sc = chain;
                    sb = blk;
                    used = nbytes[5:0];
                    put(sb, used, 8'h80);
                    for (int i = used + 1; i < 64; i++) put(sb, i, 8'h00);
                    if (used >= 56) begin
                        compress(sc, sb);
                        foreach (sb[i]) sb[i] = '0;
                    end
                    bits = {nbytes, 3'b000};
                    if (alg_act) begin
                        sb[14] = swap(bits[63:32]);
                        sb[15] = swap(bits[31:0]);
                    end else begin
                        sb[14] = bits[31:0];
                        sb[15] = bits[63:32];
                    end
                    compress(sc, sb);
                    n = alg_act ? 5 : 4;
                    for (int i = 0; i < n; i++) begin
                        o.digest_bytes = alg_act ? swap(sc[i]) : sc[i];
                        o.word_index = i[2:0];
                        o.last_word = (i == n - 1);
                        pending.push_back(o);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_digest(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest word %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.digest_bytes !== exp_w.digest_bytes) begin
                $display("%0t: digest_bytes expected %h actual %h",
                         $time, exp_w.digest_bytes, got.digest_bytes);
                errors++;
            end
            if (got.word_index !== exp_w.word_index) begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, exp_w.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== exp_w.last_word) begin
                $display("%0t: last_word expected %0d actual %0d",
                         $time, exp_w.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    longint cycles = 0;

    mdsha_in_if  cmd_ch ();
    mdsha_cfg_if cfg_ch ();
    mdsha_out_if dig_ch ();

    md5_sha1_hash_engine_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_dig   (dig_ch.source)
    );

    digest_scoreboard sb = new();
    bit stall_mode;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Worst case per word is two SHA-1 compressions plus five stalled digest
    // words; the limit is a generous multiple of that over the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: check every accepted digest word, stall on a pattern that
    // switches at random between no stalls and heavy random stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && dig_ch.valid && dig_ch.ready) sb.check_digest(dig_ch.payload);
        if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 1);
        dig_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    initial begin
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = 1'b0;
        dig_ch.ready   = 1'b0;
        stall_mode     = 1'b0;
    end

    int burst_left = 0;

    // Sends one command word; gaps fall between bursts of random length.
    // Valid is already low whenever a new burst starts.
    task automatic send_command(input logic [1:0] kind, input logic [31:0] data,
                                input logic [2:0] cnt);
        t_in_word w;
        w.kind = kind;
        w.data_bytes = data;
        w.byte_count = cnt;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= w;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(w);
        if (burst_left == 0) cmd_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        if (burst_left != 0) cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // An append may still be compressing after the last digest word.
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_algorithm(input bit alg);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= alg;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.alg_reg = alg;
    endtask

    task automatic append_random(input int nbytes);
        int c;
        while (nbytes > 0) begin
            c = (nbytes < 4) ? nbytes : $urandom_range(1, 4);
            send_command(KIND_APPEND, $urandom(), c[2:0]);
            nbytes -= c;
        end
    endtask

    initial begin
        logic [1:0] k;
        sb.init();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, field extremes, oversized and empty counts,
        // the unused kind, and the padding boundary around 55/56 bytes.
        send_command(KIND_QUERY, 32'h0, 3'd0);
        send_command(KIND_APPEND, 32'hFFFF_FFFF, 3'd7);
        send_command(KIND_APPEND, 32'h0000_0000, 3'd4);
        send_command(KIND_APPEND, 32'hDEAD_BEEF, 3'd0);
        send_command(KIND_RESERVED, 32'hFFFF_FFFF, 3'd7);
        send_command(KIND_QUERY, 32'hFFFF_FFFF, 3'd7);
        append_random(47);
        send_command(KIND_QUERY, 32'h0, 3'd0);
        send_command(KIND_APPEND, 32'h61, 3'd1);
        send_command(KIND_QUERY, 32'h0, 3'd0);
        append_random(8);
        send_command(KIND_QUERY, 32'h0, 3'd0);
        drain();

        // Register written alone leaves the running hash as it is.
        write_algorithm(1'b1);
        send_command(KIND_QUERY, 32'h0, 3'd0);
        send_command(KIND_RESTART, 32'h0, 3'd0);
        send_command(KIND_QUERY, 32'h0, 3'd0);
        append_random(56);
        send_command(KIND_QUERY, 32'h0, 3'd0);
        append_random(9);
        send_command(KIND_QUERY, 32'h0, 3'd0);
        drain();

        // Random phases across both algorithms.
        for (int ph = 0; ph < 4; ph++) begin
            write_algorithm(ph[0] ? 1'b0 : 1'b1);
            send_command(KIND_RESTART, $urandom(), $urandom_range(0, 7));
            for (int n = 0; n < 54; n++) begin
                case ($urandom_range(0, 19))
                    0, 1: k = KIND_QUERY;
                    2: k = KIND_RESTART;
                    3: k = KIND_RESERVED;
                    default: k = KIND_APPEND;
                endcase
                send_command(k, $urandom(), $urandom_range(0, 7));
            end
            drain();
        end

        i_rst_n <= 1'b1;
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
